// ----- rtl/cse_pkg.sv -----
// shared widths, register indexes, reset values and types of the can signal extractor
package cse_pkg;

  localparam int unsigned IdW      = 29;
  localparam int unsigned DataW    = 64;
  localparam int unsigned BytesW   = 4;
  localparam int unsigned StartW   = 6;
  localparam int unsigned LenW     = 7;
  localparam int unsigned FmtW     = 2;
  localparam int unsigned DescW    = 15;
  localparam int unsigned CountW   = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned ByteW    = 8;

  localparam int unsigned DefMaxPayloadBytes = 8;
  localparam int unsigned DefMaxMuxIds       = 8;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegTargetId   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSigStart   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSigLength  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSigFormat  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMuxEnable  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMuxDesc    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMuxIds     = 3'd6;
  localparam logic [CfgIdxW-1:0] RegMuxIdCount = 3'd7;

  // reset values
  localparam logic [IdW-1:0]    RstTargetId  = '0;
  localparam logic [StartW-1:0] RstSigStart  = '0;
  localparam logic [LenW-1:0]   RstSigLength = 7'd8;
  localparam logic [FmtW-1:0]   RstSigFormat = 2'd1;

  // result of one field extraction
  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] value;
  } cse_field_t;

endpackage

// ----- rtl/cse_field_extract.sv -----
// extracts one intel or motorola bit field from a can payload, with sign extension
module cse_field_extract import cse_pkg::*; (
  input  logic [DataW-1:0]  data_i,
  input  logic [BytesW-1:0] nbytes_i,
  input  logic [StartW-1:0] start_i,
  input  logic [LenW-1:0]   len_i,
  input  logic              intel_i,
  input  logic              sgn_i,
  output cse_field_t        field_o
);

  logic [DataW-1:0] moto_data;
  logic [DataW-1:0] src;
  logic [DataW-1:0] shifted;
  logic [DataW-1:0] mask;
  logic [DataW-1:0] raw;
  logic [7:0]       end_pos;
  logic [7:0]       limit;
  logic [7:0]       start_p1;
  logic [7:0]       moto_shift;
  logic [StartW-1:0] shift;
  logic [StartW-1:0] sign_idx;
  logic             len_full;
  logic             valid;

  // motorola numbering counts bits from the msb of each byte
  for (genvar b = 0; b < DataW / ByteW; b++) begin : g_byte
    for (genvar k = 0; k < ByteW; k++) begin : g_bit
      assign moto_data[b*ByteW + k] = data_i[b*ByteW + (ByteW - 1 - k)];
    end
  end

  always_comb begin
    end_pos    = 8'({2'b00, start_i}) + 8'({1'b0, len_i});
    limit      = 8'({nbytes_i, 3'b000});
    start_p1   = 8'({2'b00, start_i}) + 8'd1;
    moto_shift = start_p1 - 8'({1'b0, len_i});
    valid      = (len_i != '0) && (end_pos <= limit) && (intel_i || (start_p1 >= 8'({1'b0, len_i})));

    src      = intel_i ? data_i : moto_data;
    shift    = intel_i ? start_i : moto_shift[StartW-1:0];
    shifted  = src >> shift;
    len_full = (len_i >= LenW'(DataW));
    mask     = len_full ? '1 : ((DataW'(1) << len_i) - DataW'(1));
    raw      = shifted & mask;
    sign_idx = StartW'(len_i - LenW'(1));
    if (sgn_i && !len_full && raw[sign_idx]) begin
      raw = raw | ~mask;
    end

    field_o.valid = valid;
    field_o.value = valid ? raw : '0;
  end

endmodule

// ----- rtl/cse_mux_match.sv -----
// compares the multiplexer value against the configured list of accepted ids
module cse_mux_match import cse_pkg::*; #(
  parameter int unsigned MAX_MUX_IDS = DefMaxMuxIds
) (
  input  logic [ByteW-1:0]  mux_value_i,
  input  logic [DataW-1:0]  mux_ids_i,
  input  logic [CountW-1:0] mux_id_count_i,
  output logic              hit_o
);

  logic [CountW-1:0]      count;
  logic [MAX_MUX_IDS-1:0] lane_hit;

  assign count = (mux_id_count_i > CountW'(MAX_MUX_IDS)) ? CountW'(MAX_MUX_IDS) : mux_id_count_i;

  for (genvar k = 0; k < MAX_MUX_IDS; k++) begin : g_lane
    assign lane_hit[k] = (CountW'(k) < count) && (mux_ids_i[k*ByteW +: ByteW] == mux_value_i);
  end

  assign hit_o = |lane_hit;

endmodule

// ----- rtl/can_signal_extractor.sv -----
// top level of the can signal extractor: config registers, input and result stages
// Usage:
//   Frames enter on the input channel (in_valid_i / in_stall_o) with identifier,
//   flags, payload and byte count. Only frames whose identifier equals target_id
//   produce a transaction on the output channel (out_valid_o / out_stall_i);
//   with the multiplexer check on, the frame must also carry an accepted mux id.
//   The result holds the frame passed through, the extracted signal value and
//   an invalid flag for a field outside the payload.
//   An accepted frame first lands in the input register; the extraction and
//   match logic then loads the result register once that register is free,
//   which raises out_valid_o.
//   Throughput is one frame per cycle unless the receiver stalls; the rate is
//   set by the single pass of shift and compare logic between the two registers.
//   While the receiver stalls, the result register holds and one more frame
//   waits in the input register; non-matching frames drop and never stall.
//   Reset empties both stages and loads the register reset values.
//   Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i while
//   no frame is in flight.
module can_signal_extractor import cse_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD_BYTES = DefMaxPayloadBytes,
  parameter int unsigned MAX_MUX_IDS       = DefMaxMuxIds
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [IdW-1:0]     frame_id_i,
  input  logic               extended_i,
  input  logic               remote_i,
  input  logic [DataW-1:0]   payload_i,
  input  logic [BytesW-1:0]  payload_bytes_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [IdW-1:0]     frame_id_out_o,
  output logic               extended_out_o,
  output logic               remote_out_o,
  output logic [DataW-1:0]   payload_out_o,
  output logic [DataW-1:0]   value_bits_o,
  output logic               value_invalid_o
);

  // configuration registers
  logic [IdW-1:0]    target_id_q;
  logic [StartW-1:0] sig_start_q;
  logic [LenW-1:0]   sig_length_q;
  logic [FmtW-1:0]   sig_format_q;
  logic              mux_enable_q;
  logic [DescW-1:0]  mux_desc_q;
  logic [DataW-1:0]  mux_ids_q;
  logic [CountW-1:0] mux_id_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_id_q    <= RstTargetId;
      sig_start_q    <= RstSigStart;
      sig_length_q   <= RstSigLength;
      sig_format_q   <= RstSigFormat;
      mux_enable_q   <= 1'b0;
      mux_desc_q     <= '0;
      mux_ids_q      <= '0;
      mux_id_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegTargetId:   target_id_q    <= cfg_data_i[IdW-1:0];
        RegSigStart:   sig_start_q    <= cfg_data_i[StartW-1:0];
        RegSigLength:  sig_length_q   <= cfg_data_i[LenW-1:0];
        RegSigFormat:  sig_format_q   <= cfg_data_i[FmtW-1:0];
        RegMuxEnable:  mux_enable_q   <= cfg_data_i[0];
        RegMuxDesc:    mux_desc_q     <= cfg_data_i[DescW-1:0];
        RegMuxIds:     mux_ids_q      <= cfg_data_i;
        RegMuxIdCount: mux_id_count_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic              s1_valid_q, s1_valid_d;
  logic [IdW-1:0]    s1_id_q;
  logic              s1_ext_q;
  logic              s1_rtr_q;
  logic [DataW-1:0]  s1_data_q;
  logic [BytesW-1:0] s1_nbytes_q;

  logic       in_accept;
  logic       s1_advance;
  logic       s2_ready;
  logic       keep;
  logic       mux_hit;
  cse_field_t mux_field;
  cse_field_t sig_field;
  logic [BytesW-1:0] nbytes_sat;

  assign nbytes_sat = (s1_nbytes_q > BytesW'(MAX_PAYLOAD_BYTES)) ?
                      BytesW'(MAX_PAYLOAD_BYTES) : s1_nbytes_q;

  cse_field_extract u_mux_extract (
    .data_i   (s1_data_q),
    .nbytes_i (nbytes_sat),
    .start_i  (mux_desc_q[5:0]),
    .len_i    (mux_desc_q[12:6]),
    .intel_i  (mux_desc_q[13]),
    .sgn_i    (mux_desc_q[14]),
    .field_o  (mux_field)
  );

  cse_mux_match #(
    .MAX_MUX_IDS (MAX_MUX_IDS)
  ) u_mux_match (
    .mux_value_i    (mux_field.value[ByteW-1:0]),
    .mux_ids_i      (mux_ids_q),
    .mux_id_count_i (mux_id_count_q),
    .hit_o          (mux_hit)
  );

  cse_field_extract u_sig_extract (
    .data_i   (s1_data_q),
    .nbytes_i (nbytes_sat),
    .start_i  (sig_start_q),
    .len_i    (sig_length_q),
    .intel_i  (sig_format_q[0]),
    .sgn_i    (sig_format_q[1]),
    .field_o  (sig_field)
  );

  assign keep = s1_valid_q && (s1_id_q == target_id_q) &&
                (!mux_enable_q || (mux_field.valid && mux_hit));

  assign s2_ready   = !out_valid_o || !out_stall_i;
  // a frame that gives no result leaves without waiting for the output side
  assign s1_advance = !s1_valid_q || !keep || s2_ready;
  assign in_stall_o = !s1_advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s1_valid_d = s1_advance ? in_valid_i : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_id_q     <= frame_id_i;
      s1_ext_q    <= extended_i;
      s1_rtr_q    <= remote_i;
      s1_data_q   <= payload_i;
      s1_nbytes_q <= payload_bytes_i;
    end
  end

  // result stage
  logic out_valid_q, out_valid_d;
  logic load_out;

  assign load_out    = keep && s2_ready;
  assign out_valid_d = s2_ready ? keep : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      frame_id_out_o  <= s1_id_q;
      extended_out_o  <= s1_ext_q;
      remote_out_o    <= s1_rtr_q;
      payload_out_o   <= s1_data_q;
      value_bits_o    <= sig_field.value;
      value_invalid_o <= !sig_field.valid;
    end
  end

  assign out_valid_o = out_valid_q;

  // stall only ever comes from a held matching frame
  a_stall_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && keep && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // a frame without result never blocks the input
  a_drop_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !keep) |-> !in_stall_o)
    else $error("dropped frame stalls the input");

  // a matching frame moved forward shows up as a result
  a_keep_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (keep && s2_ready) |=> out_valid_o)
    else $error("matching frame lost");

  // an invalid field reports a zero value
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && value_invalid_o) |-> (value_bits_o == '0))
    else $error("invalid field with nonzero value");

endmodule

// ----- bench/can_signal_extractor_tb.sv -----
// self-checking testbench of the can signal extractor: random frames, shadow decoder, scoreboard
module can_signal_extractor_tb import cse_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic              ext;
    logic              rtr;
    logic [DataW-1:0]  data;
    logic [BytesW-1:0] nbytes;
  } can_frame_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic             ext;
    logic             rtr;
    logic [DataW-1:0] data;
    logic [DataW-1:0] value;
    logic             invalid;
  } decoded_signal_t;

  typedef struct packed {
    logic [IdW-1:0]    target_id;
    logic [StartW-1:0] sig_start;
    logic [LenW-1:0]   sig_length;
    logic [FmtW-1:0]   sig_format;
    logic              mux_enable;
    logic [DescW-1:0]  mux_desc;
    logic [DataW-1:0]  mux_ids;
    logic [CountW-1:0] mux_id_count;
  } extractor_cfg_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [DataW-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               out_stall = 1'b0;
  can_frame_t         cur_frame = '0;

  logic               in_stall;
  logic               out_valid;
  logic [IdW-1:0]     frame_id_out;
  logic               extended_out;
  logic               remote_out;
  logic [DataW-1:0]   payload_out;
  logic [DataW-1:0]   value_bits;
  logic               value_invalid;

  can_frame_t      pending_frames[$];
  decoded_signal_t expected_signals[$];
  extractor_cfg_t  cfg_shadow;
  decoded_signal_t drv_decoded;
  decoded_signal_t mon_decoded;
  int              frames_queued = 0;
  int              frames_sent = 0;
  int              mismatches = 0;
  int              idle_pct = 18;

  always #4 clk_i = ~clk_i;

  can_signal_extractor dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .frame_id_i     (cur_frame.id),
    .extended_i     (cur_frame.ext),
    .remote_i       (cur_frame.rtr),
    .payload_i      (cur_frame.data),
    .payload_bytes_i(cur_frame.nbytes),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .frame_id_out_o (frame_id_out),
    .extended_out_o (extended_out),
    .remote_out_o   (remote_out),
    .payload_out_o  (payload_out),
    .value_bits_o   (value_bits),
    .value_invalid_o(value_invalid)
  );

  // bit field pull in intel or motorola order, invalid when outside the payload
  function automatic cse_field_t extract_field(input logic [DataW-1:0] data, input int nbytes,
                                               input int start, input int len,
                                               input logic intel, input logic sgn);
    cse_field_t       f;
    logic [DataW-1:0] msk;
    int               nb;
    int               i;
    int               j;
    int               pos;
    f = '0;
    nb = (nbytes > int'(DefMaxPayloadBytes)) ? int'(DefMaxPayloadBytes) : nbytes;
    if (len == 0 || start + len > nb * int'(ByteW)) return f;
    // motorola field must not run below index zero
    if (!intel && start + 1 < len) return f;
    msk = (len >= int'(DataW)) ? '1 : ((64'd1 << len) - 64'd1);
    if (intel) begin
      f.value = (data >> start) & msk;
    end else begin
      for (i = 0; i < len; i++) begin
        j = start - i;
        pos = (j & ~7) + (7 - (j & 7));
        f.value[len-1-i] = data[pos];
      end
    end
    if (sgn && len < int'(DataW) && f.value[len-1]) f.value = f.value | ~msk;
    f.valid = 1'b1;
    return f;
  endfunction

  function automatic bit decode_frame(input extractor_cfg_t c, input can_frame_t fr,
                                      output decoded_signal_t d);
    cse_field_t mux_field;
    cse_field_t sig_field;
    int         cnt;
    int         k;
    bit         hit;
    d = '0;
    if (fr.id != c.target_id) return 1'b0;
    if (c.mux_enable) begin
      // mux_desc: start 5:0, length 12:6, intel 13, signed 14
      mux_field = extract_field(fr.data, int'(fr.nbytes), int'(c.mux_desc[5:0]),
                                int'(c.mux_desc[12:6]), c.mux_desc[13], c.mux_desc[14]);
      if (!mux_field.valid) return 1'b0;
      cnt = (c.mux_id_count > DefMaxMuxIds) ? int'(DefMaxMuxIds) : int'(c.mux_id_count);
      hit = 1'b0;
      for (k = 0; k < cnt; k++) begin
        if (c.mux_ids[k*ByteW +: ByteW] == mux_field.value[ByteW-1:0]) hit = 1'b1;
      end
      if (!hit) return 1'b0;
    end
    sig_field = extract_field(fr.data, int'(fr.nbytes), int'(c.sig_start), int'(c.sig_length),
                              c.sig_format[0], c.sig_format[1]);
    d.id = fr.id;
    d.ext = fr.ext;
    d.rtr = fr.rtr;
    d.data = fr.data;
    d.value = sig_field.valid ? sig_field.value : '0;
    d.invalid = !sig_field.valid;
    return 1'b1;
  endfunction

  // inverse of the extraction: writes val into the field, bits outside 0..63 are skipped
  function automatic logic [DataW-1:0] plant_field(input logic [DataW-1:0] data, input int start,
                                                   input int len, input logic intel,
                                                   input logic [DataW-1:0] val);
    logic [DataW-1:0] d;
    int               i;
    int               j;
    int               pos;
    d = data;
    for (i = 0; i < len; i++) begin
      if (intel) begin
        if (start + i < int'(DataW)) d[start+i] = val[i];
      end else begin
        j = start - i;
        if (j >= 0 && len - 1 - i < int'(DataW)) begin
          pos = (j & ~7) + (7 - (j & 7));
          d[pos] = val[len-1-i];
        end
      end
    end
    return d;
  endfunction

  function automatic can_frame_t mk_frame(input logic [IdW-1:0] id, input logic ext,
                                          input logic rtr, input logic [DataW-1:0] data,
                                          input logic [BytesW-1:0] nbytes);
    can_frame_t fr;
    fr.id = id;
    fr.ext = ext;
    fr.rtr = rtr;
    fr.data = data;
    fr.nbytes = nbytes;
    return fr;
  endfunction

  function automatic can_frame_t random_frame(input extractor_cfg_t c);
    can_frame_t fr;
    int         r;
    int         cnt;
    int         k;
    r = $urandom_range(0, 99);
    if (r < 75) fr.id = c.target_id;
    else if (r < 90) fr.id = c.target_id ^ (29'd1 << $urandom_range(0, IdW - 1));
    else fr.id = IdW'($urandom);
    fr.ext = 1'($urandom_range(0, 1));
    fr.rtr = 1'($urandom_range(0, 1));
    fr.data = {$urandom, $urandom};
    fr.nbytes = ($urandom_range(0, 99) < 70) ? 4'd8 : 4'($urandom_range(0, 15));
    cnt = (c.mux_id_count > DefMaxMuxIds) ? int'(DefMaxMuxIds) : int'(c.mux_id_count);
    // most multiplexed frames carry one of the listed ids
    if (c.mux_enable && cnt > 0 && $urandom_range(0, 99) < 85) begin
      k = $urandom_range(0, cnt - 1);
      fr.data = plant_field(fr.data, int'(c.mux_desc[5:0]), int'(c.mux_desc[12:6]),
                            c.mux_desc[13],
                            {fr.data[DataW-1:ByteW], c.mux_ids[k*ByteW +: ByteW]});
    end
    return fr;
  endfunction

  function automatic extractor_cfg_t random_config();
    extractor_cfg_t c;
    int             st;
    int             ln;
    int             lim;
    logic           intel;
    c.target_id = IdW'($urandom);
    st = $urandom_range(0, 63);
    intel = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 85) ln = intel ? $urandom_range(1, 64 - st) : $urandom_range(1, st + 1);
    else ln = $urandom_range(0, 127);
    c.sig_start = StartW'(st);
    c.sig_length = LenW'(ln);
    c.sig_format = {1'($urandom_range(0, 1)), intel};
    c.mux_enable = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 85) begin
      intel = 1'($urandom_range(0, 1));
      if (intel) begin
        st = $urandom_range(0, 56);
        lim = (64 - st < 16) ? 64 - st : 16;
      end else begin
        st = $urandom_range(7, 63);
        lim = (st + 1 < 16) ? st + 1 : 16;
      end
      ln = $urandom_range(8, lim);
      c.mux_desc[5:0] = 6'(st);
      c.mux_desc[12:6] = 7'(ln);
      c.mux_desc[13] = intel;
      c.mux_desc[14] = 1'($urandom_range(0, 1));
    end else begin
      c.mux_desc = DescW'($urandom);
    end
    c.mux_ids = {$urandom, $urandom};
    c.mux_id_count = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(1, 8))
                                                  : 4'($urandom_range(0, 15));
    return c;
  endfunction

  // unused upper data bits carry junk, the block must drop them
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] val,
                           input int w);
    logic [DataW-1:0] junk;
    junk = {$urandom, $urandom};
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= (w >= int'(DataW)) ? val : ((junk << w) | val);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_config(input extractor_cfg_t c);
    write_reg(RegTargetId, DataW'(c.target_id), int'(IdW));
    write_reg(RegSigStart, DataW'(c.sig_start), int'(StartW));
    write_reg(RegSigLength, DataW'(c.sig_length), int'(LenW));
    write_reg(RegSigFormat, DataW'(c.sig_format), int'(FmtW));
    write_reg(RegMuxEnable, DataW'(c.mux_enable), 1);
    write_reg(RegMuxDesc, DataW'(c.mux_desc), int'(DescW));
    write_reg(RegMuxIds, c.mux_ids, int'(DataW));
    write_reg(RegMuxIdCount, DataW'(c.mux_id_count), int'(CountW));
    cfg_shadow = c;
  endtask

  task automatic queue_frame(input can_frame_t fr);
    pending_frames.push_back(fr);
    frames_queued++;
  endtask

  // sender holds off until every queued frame went in and every decoded signal came out
  task automatic wait_idle();
    while (frames_sent != frames_queued || expected_signals.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [DataW-1:0] exp_v,
                             input logic [DataW-1:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      $display("%0t %s: expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // frame driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (decode_frame(cfg_shadow, cur_frame, drv_decoded))
          expected_signals.push_back(drv_decoded);
        frames_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_frames.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          cur_frame <= pending_frames.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_signals.size() == 0) begin
          mismatches++;
          $display("%0t unexpected transaction: expected none actual frame_id %h",
                   $time, frame_id_out);
        end else begin
          mon_decoded = expected_signals.pop_front();
          check_field("frame_id_out", DataW'(mon_decoded.id), DataW'(frame_id_out));
          check_field("extended_out", DataW'(mon_decoded.ext), DataW'(extended_out));
          check_field("remote_out", DataW'(mon_decoded.rtr), DataW'(remote_out));
          check_field("payload_out", mon_decoded.data, payload_out);
          check_field("value_bits", mon_decoded.value, value_bits);
          check_field("value_invalid", DataW'(mon_decoded.invalid), DataW'(value_invalid));
        end
      end
      out_stall <= ($urandom_range(0, 99) < idle_pct);
    end
  end

  initial begin
    extractor_cfg_t c;
    extractor_cfg_t base;
    int             p;
    int             n;
    int             i;
    base = '0;
    base.target_id = RstTargetId;
    base.sig_start = RstSigStart;
    base.sig_length = RstSigLength;
    base.sig_format = RstSigFormat;
    cfg_shadow = base;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: byte 0 intel unsigned, identifier 0
    queue_frame(mk_frame('0, 1'b0, 1'b0, '0, 4'd8));
    queue_frame(mk_frame('0, 1'b1, 1'b1, '1, 4'd8));
    queue_frame(mk_frame('0, 1'b0, 1'b0, {$urandom, $urandom}, 4'd0));
    queue_frame(mk_frame('0, 1'b0, 1'b1, 64'hA5, 4'd1));
    queue_frame(mk_frame('0, 1'b1, 1'b0, {$urandom, $urandom}, 4'd15));
    queue_frame(mk_frame(29'd1, 1'b0, 1'b0, {$urandom, $urandom}, 4'd8));
    queue_frame(mk_frame('1, 1'b1, 1'b1, {$urandom, $urandom}, 4'd8));
    wait_idle();

    // full 64 bit signed field, then one byte short
    c = base;
    c.target_id = '1;
    c.sig_length = 7'd64;
    c.sig_format = 2'd3;
    apply_config(c);
    queue_frame(mk_frame('1, 1'b1, 1'b1, 64'h8000_0000_0000_0001, 4'd8));
    queue_frame(mk_frame('1, 1'b0, 1'b0, {$urandom, $urandom}, 4'd7));
    wait_idle();

    // single motorola signed bit at the top index
    c = base;
    c.target_id = 29'h0AAA_AAAA;
    c.sig_start = 6'd63;
    c.sig_length = 7'd1;
    c.sig_format = 2'd2;
    apply_config(c);
    queue_frame(mk_frame(29'h0AAA_AAAA, 1'b0, 1'b0, 64'h0100_0000_0000_0000, 4'd8));
    queue_frame(mk_frame(29'h0AAA_AAAA, 1'b1, 1'b0, 64'hFEFF_FFFF_FFFF_FFFF, 4'd8));
    wait_idle();

    // motorola field running below index zero
    c.sig_start = 6'd3;
    c.sig_length = 7'd8;
    c.sig_format = 2'd0;
    apply_config(c);
    queue_frame(mk_frame(29'h0AAA_AAAA, 1'b0, 1'b1, '1, 4'd8));
    wait_idle();

    // zero length
    c.sig_length = 7'd0;
    c.sig_format = 2'd1;
    apply_config(c);
    queue_frame(mk_frame(29'h0AAA_AAAA, 1'b0, 1'b0, {$urandom, $urandom}, 4'd8));
    wait_idle();

    // mux id in byte 0, id count saturates
    c = base;
    c.mux_enable = 1'b1;
    c.mux_desc = (DescW'(8) << 6) | (DescW'(1) << 13);
    c.mux_ids = 64'h0706_0504_0302_0100;
    c.mux_id_count = 4'd15;
    apply_config(c);
    queue_frame(mk_frame('0, 1'b0, 1'b0, 64'h1234_5678_9ABC_DE07, 4'd8));
    queue_frame(mk_frame('0, 1'b0, 1'b0, 64'h1234_5678_9ABC_DE08, 4'd8));
    queue_frame(mk_frame('0, 1'b1, 1'b1, 64'h0, 4'd0));
    wait_idle();
    c.mux_id_count = 4'd3;
    apply_config(c);
    queue_frame(mk_frame('0, 1'b0, 1'b0, 64'h0000_0000_0000_FF03, 4'd2));
    queue_frame(mk_frame('0, 1'b0, 1'b0, 64'h0000_0000_0000_FF02, 4'd2));
    wait_idle();
    c.mux_id_count = 4'd0;
    apply_config(c);
    queue_frame(mk_frame('0, 1'b0, 1'b0, 64'h0, 4'd8));
    wait_idle();

    // random phases, first two at the register extremes
    for (p = 0; p < 10; p++) begin
      if (p == 0) begin
        c = '0;
      end else if (p == 1) begin
        c = '1;
        c.mux_enable = 1'b0;
      end else begin
        c = random_config();
      end
      n = (p < 2) ? 40 : 90;
      idle_pct = (p == 4) ? 0 : 18;
      apply_config(c);
      for (i = 0; i < n; i++) begin
        queue_frame(random_frame(c));
        if (i == n / 2) wait_idle();
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
